// ===== hdl/bounded_positional_list_macros.svh =====
// assertion helpers for the positional list block
`ifndef BOUNDED_POSITIONAL_LIST_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_positional_list: same-cycle check failed");

// next-cycle implication, checked outside reset
`define BPL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_positional_list: next-cycle check failed");

`endif

// ===== hdl/bpl_pkg.sv =====
`default_nettype none

package bpl_pkg;

    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 3;
    localparam int LIST_MAX_DEF = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd4;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/bpl_ifs.sv =====
`default_nettype none

// command channel
interface bpl_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [bpl_pkg::FUNC_W-1:0]          func;
    logic [bpl_pkg::POS_W-1:0]           position;
    logic signed [bpl_pkg::WORD_W-1:0]   value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

// result channel
interface bpl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bpl_pkg::STATUS_W-1:0]        status;
    logic signed [bpl_pkg::WORD_W-1:0]   word;
    logic [bpl_pkg::POS_W-1:0]           found_at;
    logic [bpl_pkg::POS_W-1:0]           count;
    logic                                last;

    modport source (output valid, status, word, found_at, count, last, input ready);
    modport sink   (input valid, status, word, found_at, count, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpl_mem.sv =====
`default_nettype none

// word store: one write port, one registered read port
module bpl_mem #(
    parameter int DEPTH = bpl_pkg::LIST_MAX_DEF,
    parameter int AW    = 5
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [bpl_pkg::WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]              raddr,
    output logic      [bpl_pkg::WORD_W-1:0] rdata
);

    logic [bpl_pkg::WORD_W-1:0] mem [DEPTH];
    logic [bpl_pkg::WORD_W-1:0] rdata_reg;

    // write and registered read, read returns the old word on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/bounded_positional_list.sv =====
// insert moves the words from the position on up a slot, then stores the new word;
// delete reads the word, then moves later words down; get reads one word; search
// compares words in order until a match; dump returns one result per stored word
// one command at a time; the write port moves one word per cycle while shifting
// reset: asynchronous, clears the word count and the sequencer; stored words stay
// undefined and are never read before they are written, so no clearing pass is needed
`default_nettype none

`include "bounded_positional_list_macros.svh"

module bounded_positional_list #(
    parameter int LIST_MAX = bpl_pkg::LIST_MAX_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bpl_cmd_if.sink  cmd,
    bpl_rsp_if.source rsp
);

    localparam int AW = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
    localparam int CW = $clog2(LIST_MAX + 1);
    localparam int PW = ((CW > bpl_pkg::POS_W) ? CW : bpl_pkg::POS_W) + 1;
    localparam int WW = bpl_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_A,
        S_DEL_B,
        S_GET_A,
        S_GET_B,
        S_MOVE,
        S_MOVE_LAST,
        S_PUT,
        S_SRCH,
        S_DUMP_A,
        S_DUMP_B,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     stop_reg, stop_next;
    logic [AW-1:0]     base_reg, base_next;
    logic              dir_up_reg, dir_up_next;
    logic              is_ins_reg, is_ins_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              done_reg, done_next;
    logic [WW-1:0]     val_reg, val_next;
    logic [CW-1:0]     used_reg, used_next;
    bpl_pkg::status_t  st_reg, st_next;
    logic [WW-1:0]     word_reg, word_next;
    logic [CW-1:0]     found_reg, found_next;

    logic              ovalid_reg, ovalid_next;
    bpl_pkg::status_t  ostatus_reg, ostatus_next;
    logic [WW-1:0]     oword_reg, oword_next;
    logic [CW-1:0]     ofound_reg, ofound_next;
    logic [CW-1:0]     ocount_reg, ocount_next;
    logic              olast_reg, olast_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WW-1:0]     rd_data;

    logic              cmd_acc;
    logic              slot_free;
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     used_w;
    logic [AW-1:0]     pos_m1;
    logic [AW-1:0]     used_m1;

    bpl_mem #(
        .DEPTH (LIST_MAX),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    // handshake and common decode
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign slot_free = !ovalid_reg || rsp.ready;
    assign pos_w     = PW'(cmd.position);
    assign used_w    = PW'(used_reg);
    assign pos_m1    = AW'(pos_w - PW'(1));
    assign used_m1   = AW'(used_reg - CW'(1));

    // sequencer next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        stop_next      = stop_reg;
        base_next      = base_reg;
        dir_up_next    = dir_up_reg;
        is_ins_next    = is_ins_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        done_next      = done_reg;
        val_next       = val_reg;
        used_next      = used_reg;
        st_next        = st_reg;
        word_next      = word_reg;
        found_next     = found_reg;

        ovalid_next    = ovalid_reg && !rsp.ready;
        ostatus_next   = ostatus_reg;
        oword_next     = oword_reg;
        ofound_next    = ofound_reg;
        ocount_next    = ocount_reg;
        olast_next     = olast_reg;

        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rd_data;
        mem_raddr      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    val_next   = cmd.value;
                    word_next  = '0;
                    found_next = '0;
                    pend_next  = 1'b0;
                    done_next  = 1'b0;
                    st_next    = bpl_pkg::ST_OK;
                    case (cmd.func)
                        bpl_pkg::FN_INSERT:
                        begin
                            is_ins_next = 1'b1;
                            base_next   = pos_m1;
                            if (used_reg == CW'(LIST_MAX))
                            begin
                                st_next    = bpl_pkg::ST_FULL;
                                state_next = S_EMIT;
                            end
                            else if (pos_w == '0 || pos_w > used_w + PW'(1))
                            begin
                                st_next    = bpl_pkg::ST_BADPOS;
                                state_next = S_EMIT;
                            end
                            else if (pos_w <= used_w)
                            begin
                                idx_next    = used_m1;
                                stop_next   = pos_m1;
                                dir_up_next = 1'b1;
                                state_next  = S_MOVE;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        bpl_pkg::FN_DELETE:
                        begin
                            is_ins_next = 1'b0;
                            base_next   = pos_m1;
                            idx_next    = pos_m1;
                            if (used_reg == '0)
                            begin
                                st_next    = bpl_pkg::ST_EMPTY;
                                state_next = S_EMIT;
                            end
                            else if (pos_w == '0 || pos_w > used_w)
                            begin
                                st_next    = bpl_pkg::ST_BADPOS;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DEL_A;
                            end
                        end
                        bpl_pkg::FN_SEARCH:
                        begin
                            idx_next = '0;
                            if (used_reg == '0)
                            begin
                                st_next    = bpl_pkg::ST_NOTFOUND;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        bpl_pkg::FN_GET:
                        begin
                            idx_next = pos_m1;
                            if (pos_w == '0 || pos_w > used_w)
                            begin
                                st_next    = bpl_pkg::ST_BADPOS;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_GET_A;
                            end
                        end
                        bpl_pkg::FN_DUMP:
                        begin
                            idx_next = '0;
                            if (used_reg == '0)
                            begin
                                st_next    = bpl_pkg::ST_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DUMP_A;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // read the word being deleted
            S_DEL_A:
            begin
                state_next = S_DEL_B;
            end

            S_DEL_B:
            begin
                word_next = rd_data;
                if (PW'(base_reg) + PW'(1) < used_w)
                begin
                    idx_next    = AW'(PW'(base_reg) + PW'(1));
                    stop_next   = used_m1;
                    dir_up_next = 1'b0;
                    state_next  = S_MOVE;
                end
                else
                begin
                    used_next  = used_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end

            S_GET_A:
            begin
                state_next = S_GET_B;
            end

            S_GET_B:
            begin
                word_next  = rd_data;
                state_next = S_EMIT;
            end

            // pipelined shift: read one word, write the previous one a slot over
            S_MOVE:
            begin
                mem_we         = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = dir_up_reg ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));
                if (idx_reg == stop_reg)
                begin
                    state_next = S_MOVE_LAST;
                end
                else
                begin
                    idx_next = dir_up_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                end
            end

            S_MOVE_LAST:
            begin
                mem_we    = 1'b1;
                pend_next = 1'b0;
                if (is_ins_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    used_next  = used_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end

            // store the new word into the opened slot
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = base_reg;
                mem_wdata  = val_reg;
                used_next  = used_reg + CW'(1);
                state_next = S_EMIT;
            end

            // pipelined scan: issue a read and compare the previous word
            S_SRCH:
            begin
                if (!done_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    if (idx_reg == used_m1)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (rd_data == val_reg)
                    begin
                        found_next = CW'(pend_addr_reg) + CW'(1);
                        st_next    = bpl_pkg::ST_OK;
                        state_next = S_EMIT;
                    end
                    else if (pend_addr_reg == used_m1)
                    begin
                        st_next    = bpl_pkg::ST_NOTFOUND;
                        state_next = S_EMIT;
                    end
                end
            end

            S_DUMP_A:
            begin
                state_next = S_DUMP_B;
            end

            // one transaction per stored word
            S_DUMP_B:
            begin
                if (slot_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = bpl_pkg::ST_OK;
                    oword_next   = rd_data;
                    ofound_next  = '0;
                    ocount_next  = used_reg;
                    olast_next   = (idx_reg == used_m1);
                    if (idx_reg == used_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_DUMP_A;
                    end
                end
            end

            // single-result operations finish here
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = st_reg;
                    oword_next   = word_reg;
                    ofound_next  = found_reg;
                    ocount_next  = used_reg;
                    olast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, word count and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        stop_reg      <= stop_next;
        base_reg      <= base_next;
        dir_up_reg    <= dir_up_next;
        is_ins_reg    <= is_ins_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        st_reg        <= st_next;
        word_reg      <= word_next;
        found_reg     <= found_next;
        ostatus_reg   <= ostatus_next;
        oword_reg     <= oword_next;
        ofound_reg    <= ofound_next;
        ocount_reg    <= ocount_next;
        olast_reg     <= olast_next;
    end

    // result channel
    assign rsp.valid    = ovalid_reg;
    assign rsp.status   = ostatus_reg;
    assign rsp.word     = oword_reg;
    assign rsp.found_at = bpl_pkg::POS_W'(ofound_reg);
    assign rsp.count    = bpl_pkg::POS_W'(ocount_reg);
    assign rsp.last     = olast_reg;

    // checks
    `BPL_ASSERT_IMP(a_used_bound, 1'b1, used_reg <= CW'(LIST_MAX))
    `BPL_ASSERT_NXT(a_put_grows, state_reg == S_PUT, used_reg == $past(used_reg) + CW'(1))
    `BPL_ASSERT_IMP(a_move_no_clash, mem_we && state_reg == S_MOVE, mem_waddr != mem_raddr)
    `BPL_ASSERT_IMP(a_result_waits, ovalid_reg && !rsp.ready && state_reg == S_EMIT,
                    state_next == S_EMIT)

endmodule

`default_nettype wire
